FILE: rtl/rational_arithmetic_unit_macros.svh
// ----------------------------------------------------------------------------
// Rational arithmetic unit assertion macros
// Implication checks sampled on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// same-cycle implication
`define RAU_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RAU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Operation and status codes, command and status bundles for the rational unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

	localparam int DW = 64;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_NEG = 3'd4;
	localparam logic [2:0] OP_ABS = 3'd5;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_DIVZERO  = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	typedef struct packed {
		logic load;
		logic mul_x;
		logic mul_y;
		logic mul_d;
		logic comb;
		logic gcd_init;
		logic gcd_step;
		logic div_init;
		logic div_step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic early;
		logic mag_zero;
		logic gcd_done;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

FILE: rtl/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: multiply steps, combine, binary gcd loop, dual division, emit.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_ctrl
	import rau_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_PRE   = 11'b00000000010,
		S_MULX  = 11'b00000000100,
		S_MULY  = 11'b00000001000,
		S_MULD  = 11'b00000010000,
		S_COMB  = 11'b00000100000,
		S_GINIT = 11'b00001000000,
		S_GCD   = 11'b00010000000,
		S_DINIT = 11'b00100000000,
		S_DIV   = 11'b01000000000,
		S_DONE  = 11'b10000000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_PRE;
				end
			end
			S_PRE: state_d = sts.early ? S_DONE : S_MULX;
			S_MULX: begin
				cmd.mul_x = 1'b1;
				state_d = S_MULY;
			end
			S_MULY: begin
				cmd.mul_y = 1'b1;
				state_d = S_MULD;
			end
			S_MULD: begin
				cmd.mul_d = 1'b1;
				state_d = S_COMB;
			end
			S_COMB: begin
				cmd.comb = 1'b1;
				state_d = S_GINIT;
			end
			S_GINIT: begin
				if (sts.mag_zero) begin
					state_d = S_DONE;
				end else begin
					cmd.gcd_init = 1'b1;
					state_d = S_GCD;
				end
			end
			S_GCD: begin
				if (sts.gcd_done) begin
					state_d = S_DINIT;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			S_DINIT: begin
				cmd.div_init = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				if (sts.div_done) begin
					state_d = S_DONE;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/rau_datapath.sv
// ----------------------------------------------------------------------------
// rau_datapath
// Shared multiplier, sign combine, binary gcd, two restoring dividers, output.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_datapath
	import rau_pkg::*;
#(
	parameter int WIDTH = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  wire  [2:0]  in_op,
	input  wire  [31:0] in_a_num,
	input  wire  [30:0] in_a_den,
	input  wire  [31:0] in_b_num,
	input  wire  [30:0] in_b_den,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [31:0] out_r_num,
	output logic [30:0] out_r_den,
	output logic [1:0]  out_status
);

	localparam logic [DW-1:0] LIM = DW'(1) << (WIDTH - 1);

	logic [2:0]    op_q;
	logic          sa_q, sb_q, neg_q;
	logic [31:0]   ma_q, mb_q;
	logic [30:0]   ad_q, bd_q;
	logic          early_q, magz_q;
	logic [1:0]    early_st_q;
	logic [DW-1:0] x_q, y_q, den_q, mag_q;
	logic [DW-1:0] u_q, v_q, g_q, qm_q, qd_q, rm_q, rd_q;
	logic [5:0]    k_q;
	logic [6:0]    cnt_q;
	logic          valid_q;
	logic [31:0]   rnum_q;
	logic [30:0]   rden_q;
	logic [1:0]    rst_q;

	logic          ld_early;
	logic [1:0]    ld_st;
	logic [31:0]   mul_a, mul_b;
	logic [DW-1:0] prod;
	logic          sbe;
	logic [DW-1:0] mag_d;
	logic          neg_d;
	logic [DW:0]   shm, shd;
	logic [DW:0]   gx;
	logic          ovf;
	logic [31:0]   fnum;
	logic [30:0]   fden;
	logic [1:0]    fst;

	always_comb begin
		ld_early = 1'b0;
		ld_st = ST_OK;
		if (in_op > OP_ABS) begin
			ld_early = 1'b1;
		end else if (in_a_den == '0) begin
			ld_early = 1'b1;
			ld_st = ST_DIVZERO;
		end else if (in_op < OP_NEG && in_b_den == '0) begin
			ld_early = 1'b1;
			ld_st = ST_DIVZERO;
		end else if (in_op == OP_DIV && in_b_num == '0) begin
			ld_early = 1'b1;
			ld_st = ST_DIVZERO;
		end
	end

	always_comb begin
		mul_a = ma_q;
		mul_b = {1'b0, bd_q};
		if (cmd.mul_x) begin
			mul_a = ma_q;
			if (op_q == OP_MUL) begin
				mul_b = mb_q;
			end else if (op_q >= OP_NEG) begin
				mul_b = 32'd1;
			end
		end else if (cmd.mul_y) begin
			mul_a = mb_q;
			mul_b = {1'b0, ad_q};
		end else begin
			mul_a = {1'b0, ad_q};
			if (op_q == OP_DIV) begin
				mul_b = mb_q;
			end else if (op_q >= OP_NEG) begin
				mul_b = 32'd1;
			end
		end
	end

	assign prod = DW'(mul_a) * DW'(mul_b);

	always_comb begin
		sbe = (op_q == OP_SUB) ? !sb_q : sb_q;
		mag_d = x_q;
		neg_d = 1'b0;
		case (op_q)
			OP_ADD, OP_SUB: begin
				if (sa_q == sbe) begin
					mag_d = x_q + y_q;
					neg_d = sa_q;
				end else if (x_q >= y_q) begin
					mag_d = x_q - y_q;
					neg_d = sa_q;
				end else begin
					mag_d = y_q - x_q;
					neg_d = sbe;
				end
			end
			OP_MUL, OP_DIV: neg_d = sa_q ^ sb_q;
			OP_NEG: neg_d = !sa_q;
			default: neg_d = 1'b0;
		endcase
	end

	assign gx  = {1'b0, g_q};
	assign shm = {rm_q, qm_q[DW-1]};
	assign shd = {rd_q, qd_q[DW-1]};

	always_comb begin
		ovf = (qd_q > LIM - DW'(1)) || (neg_q ? (qm_q > LIM) : (qm_q > LIM - DW'(1)));
		fnum = '0;
		fden = 31'd1;
		fst = ST_OK;
		if (early_q) begin
			fst = early_st_q;
		end else if (magz_q) begin
			fst = ST_OK;
		end else if (ovf) begin
			fst = ST_OVERFLOW;
		end else begin
			fnum = neg_q ? (32'd0 - qm_q[31:0]) : qm_q[31:0];
			fden = qd_q[30:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_op;
			sa_q <= in_a_num[31];
			sb_q <= in_b_num[31];
			ma_q <= in_a_num[31] ? (32'd0 - in_a_num) : in_a_num;
			mb_q <= in_b_num[31] ? (32'd0 - in_b_num) : in_b_num;
			ad_q <= in_a_den;
			bd_q <= in_b_den;
			early_q <= ld_early;
			early_st_q <= ld_st;
		end
		if (cmd.mul_x) x_q <= prod;
		if (cmd.mul_y) y_q <= prod;
		if (cmd.mul_d) den_q <= prod;
		if (cmd.comb) begin
			mag_q <= mag_d;
			neg_q <= neg_d;
			magz_q <= (mag_d == '0);
		end
		if (cmd.gcd_init) begin
			u_q <= mag_q;
			v_q <= den_q;
			k_q <= '0;
		end else if (cmd.gcd_step) begin
			if (!u_q[0] && !v_q[0]) begin
				u_q <= u_q >> 1;
				v_q <= v_q >> 1;
				k_q <= k_q + 6'd1;
			end else if (!u_q[0]) begin
				u_q <= u_q >> 1;
			end else if (!v_q[0]) begin
				v_q <= v_q >> 1;
			end else if (u_q >= v_q) begin
				u_q <= u_q - v_q;
			end else begin
				v_q <= v_q - u_q;
			end
		end
		if (cmd.div_init) begin
			g_q <= (u_q | v_q) << k_q;
			qm_q <= mag_q;
			qd_q <= den_q;
			rm_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + 7'd1;
			if (shm >= gx) begin
				rm_q <= DW'(shm - gx);
				qm_q <= {qm_q[DW-2:0], 1'b1};
			end else begin
				rm_q <= shm[DW-1:0];
				qm_q <= {qm_q[DW-2:0], 1'b0};
			end
			if (shd >= gx) begin
				rd_q <= DW'(shd - gx);
				qd_q <= {qd_q[DW-2:0], 1'b1};
			end else begin
				rd_q <= shd[DW-1:0];
				qd_q <= {qd_q[DW-2:0], 1'b0};
			end
		end
		if (cmd.emit) begin
			rnum_q <= fnum;
			rden_q <= fden;
			rst_q <= fst;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	assign sts.early    = early_q;
	assign sts.mag_zero = magz_q;
	assign sts.gcd_done = (u_q == '0) || (v_q == '0);
	assign sts.div_done = (cnt_q == 7'(DW));
	assign sts.out_free = !valid_q || out_ready;

	assign out_valid  = valid_q;
	assign out_r_num  = rnum_q;
	assign out_r_den  = rden_q;
	assign out_status = rst_q;

endmodule

`default_nettype wire

FILE: rtl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Add, subtract, multiply, divide, negate or take |a| of fractions, reduced.
// ----------------------------------------------------------------------------
// Input stream s_axis: tuser carries op, tdata carries a_num, a_den, b_num,
// b_den. An item is taken when s_axis_tvalid and s_axis_tready are high.
// Output stream m_axis: tdata carries r_num, r_den; tuser carries status.
// One item is in work at a time. A special case (unused op, zero
// denominator, zero divisor) goes straight to the result, and a zero
// result skips the gcd loop and the dividers. Otherwise the binary gcd
// runs on the 64-bit numerator and denominator, and its loop and the 64
// steps of the paired restoring dividers set the time an item takes.
// The result becomes valid in the same cycle as the next input can be taken.
// The result sits in an output register; the next input is taken while it
// waits. If m_axis_tready stays low, the finished next result waits inside
// and no further input is taken until the register frees.
// Reset clears the sequencer and the output valid; the block then waits
// for input with no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rational_arithmetic_unit_macros.svh"

module rational_arithmetic_unit
	import rau_pkg::*;
#(
	parameter int WIDTH = 32
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	input  wire  [127:0] s_axis_tdata,  // a_num[31:0], a_den[62:32], b_num[94:63], b_den[125:95]
	input  wire  [2:0]   s_axis_tuser,  // op[2:0]
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	output logic [63:0]  m_axis_tdata,  // r_num[31:0], r_den[62:32]
	output logic [1:0]   m_axis_tuser   // status[1:0]
);

	cmd_t        cmd;
	sts_t        sts;
	logic [31:0] r_num;
	logic [30:0] r_den;
	logic        res_err;
	logic        res_zero;
	logic        res_unit;

	rau_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rau_datapath #(
		.WIDTH (WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_op      (s_axis_tuser),
		.in_a_num   (s_axis_tdata[31:0]),
		.in_a_den   (s_axis_tdata[62:32]),
		.in_b_num   (s_axis_tdata[94:63]),
		.in_b_den   (s_axis_tdata[125:95]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_r_num  (r_num),
		.out_r_den  (r_den),
		.out_status (m_axis_tuser)
	);

	assign m_axis_tdata = {1'b0, r_den, r_num};

	assign res_err  = m_axis_tvalid && (m_axis_tuser != ST_OK);
	assign res_zero = m_axis_tvalid && (r_num == '0);
	assign res_unit = (r_num == '0) && (r_den == 31'd1);

	`RAU_ASSERT_NEXT(a_busy_after_load, cmd.load, !s_axis_tready, "accepted while busy")
	`RAU_ASSERT_IMPL(a_err_zero, res_err, res_unit, "error result not zero over one")
	`RAU_ASSERT_IMPL(a_zero_den_one, res_zero, r_den == 31'd1, "zero without unit denominator")
	`RAU_ASSERT_IMPL(a_den_nonzero, m_axis_tvalid, r_den != '0, "zero result denominator")

endmodule

`default_nettype wire

FILE: tb/rational_arithmetic_unit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit result checker
// Watches both streams, computes the reduced fraction for every accepted
// operand transaction and compares each result transaction in order.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_checker
	import rau_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	input  wire         s_axis_tready,
	input  wire [127:0] s_axis_tdata,
	input  wire [2:0]   s_axis_tuser,
	input  wire         m_axis_tvalid,
	input  wire         m_axis_tready,
	input  wire [63:0]  m_axis_tdata,
	input  wire [1:0]   m_axis_tuser,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [31:0] num;
		logic [30:0] den;
		logic [1:0]  status;
	} fraction_t;

	fraction_t results_due[$];

	assign pending = results_due.size();

	function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
		logic [63:0] t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic fraction_t reduce(input bit neg, input logic [63:0] mag,
			input logic [63:0] den);
		fraction_t r;
		logic [63:0] g;
		logic [63:0] lim;
		lim = 64'd1 << 31;
		r = '{num: 32'd0, den: 31'd1, status: ST_OK};
		if (mag == 0)
			return r;
		g = gcd64(mag, den);
		mag = mag / g;
		den = den / g;
		if (den > lim - 1 || (neg ? mag > lim : mag > lim - 1)) begin
			r.status = ST_OVERFLOW;
			return r;
		end
		r.num = neg ? 32'(64'd0 - mag) : mag[31:0];
		r.den = den[30:0];
		return r;
	endfunction

	function automatic fraction_t compute_fraction(input logic [2:0] op,
			input logic [127:0] d);
		fraction_t zero_div;
		logic [63:0] an, ad, bn, bd, ma, mb, x, y;
		bit sa, sb;
		an = {32'd0, d[31:0]};
		ad = {33'd0, d[62:32]};
		bn = {32'd0, d[94:63]};
		bd = {33'd0, d[125:95]};
		sa = d[31];
		sb = d[94];
		ma = sa ? 64'h1_0000_0000 - an : an;
		mb = sb ? 64'h1_0000_0000 - bn : bn;
		zero_div = '{num: 32'd0, den: 31'd1, status: ST_DIVZERO};
		if (op > OP_ABS)
			return '{num: 32'd0, den: 31'd1, status: ST_OK};
		if (ad == 0)
			return zero_div;
		if (op == OP_NEG)
			return reduce(!sa, ma, ad);
		if (op == OP_ABS)
			return reduce(1'b0, ma, ad);
		if (bd == 0)
			return zero_div;
		case (op)
			OP_ADD, OP_SUB: begin
				if (op == OP_SUB)
					sb = !sb;
				x = ma * bd;
				y = mb * ad;
				if (sa == sb)
					return reduce(sa, x + y, ad * bd);
				if (x >= y)
					return reduce(sa, x - y, ad * bd);
				return reduce(sb, y - x, ad * bd);
			end
			OP_MUL: return reduce(sa != sb, ma * mb, ad * bd);
			default: begin
				if (mb == 0)
					return zero_div;
				return reduce(sa != sb, ma * bd, ad * mb);
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		fraction_t want;
		if (!arst_n) begin
			fail_count = 0;
			results_due.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (results_due.size() == 0)
					report_mismatch("unexpected result", m_axis_tdata[31:0], 32'd0);
				else begin
					want = results_due.pop_front();
					if (m_axis_tdata[31:0] != want.num)
						report_mismatch("r_num", m_axis_tdata[31:0], want.num);
					if (m_axis_tdata[62:32] != want.den)
						report_mismatch("r_den", 32'(m_axis_tdata[62:32]), 32'(want.den));
					if (m_axis_tuser != want.status)
						report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				results_due.push_back(compute_fraction(s_axis_tuser, s_axis_tdata));
		end
	end

endmodule

FILE: tb/rational_arithmetic_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives directed corner fractions and random operand pairs through the unit
// under varying stream stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_test;
	import rau_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata;
	logic [2:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [63:0]  m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	int           fail_count;
	int           pending;
	int           send_idle_pct;
	int           recv_idle_pct;
	int           quiet_cycles;

	rational_arithmetic_unit #(.WIDTH(32)) dut (.*);

	rational_arithmetic_unit_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver stall and watchdog
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("[rational_arithmetic_unit] ERROR");
			$finish;
		end
	end

	function automatic logic [31:0] pick_num();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'd0;
			3: return 32'($signed($urandom_range(40)) - 20);
			4: return 32'($signed($urandom_range(2000)) - 1000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [30:0] pick_den();
		case ($urandom_range(4))
			0: return 31'h7fff_ffff;
			1: return 31'd1;
			2: return 31'($urandom_range(30) + 1);
			3: return 31'($urandom_range(5000) + 1);
			default: return 31'($urandom | 1);
		endcase
	endfunction

	task automatic send_op(input logic [2:0] op, input logic [31:0] an, input logic [30:0] ad,
			input logic [31:0] bn, input logic [30:0] bd);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {2'b00, bd, bn, ad, an};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	initial begin
		logic [2:0] op;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		quiet_cycles = 0;
		send_idle_pct = 38;
		recv_idle_pct = 67;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_op(OP_ADD, 32'h7fff_ffff, 31'd1, 32'h7fff_ffff, 31'd1);
		send_op(OP_SUB, 32'h8000_0000, 31'd1, 32'h7fff_ffff, 31'd1);
		send_op(OP_MUL, 32'h8000_0000, 31'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
		send_op(OP_DIV, 32'd3, 31'd4, 32'd0, 31'd5);
		send_op(OP_DIV, 32'd0, 31'd4, 32'd0, 31'd5);
		send_op(OP_DIV, 32'h8000_0000, 31'd1, 32'hffff_ffff, 31'd1);
		send_op(OP_NEG, 32'h8000_0000, 31'd1, 32'd0, 31'd0);
		send_op(OP_NEG, 32'd6, 31'd4, 32'd1, 31'd1);
		send_op(OP_ABS, 32'h8000_0000, 31'd3, 32'd0, 31'd1);
		send_op(OP_ABS, 32'hffff_fffa, 31'd9, 32'd0, 31'd1);
		send_op(OP_ADD, 32'd1, 31'd0, 32'd1, 31'd2);
		send_op(OP_MUL, 32'd1, 31'd2, 32'd1, 31'd0);
		send_op(OP_NEG, 32'd1, 31'd0, 32'd1, 31'd1);
		send_op(OP_ADD, 32'd1, 31'd3, 32'hffff_ffff, 31'd3);
		send_op(OP_SUB, 32'd1, 31'h7fff_ffff, 32'd1, 31'h7fff_fffe);
		send_op(3'd6, 32'd5, 31'd2, 32'd1, 31'd2);
		send_op(3'd7, 32'hffff_ffff, 31'h7fff_ffff, 32'hffff_ffff, 31'h7fff_ffff);
		send_op(OP_MUL, 32'd4, 31'd6, 32'd9, 31'd8);
		send_op(OP_DIV, 32'hffff_fffe, 31'd3, 32'd4, 31'd9);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 67 : 0;
			recv_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 38 : 0;
			for (int i = 0; i < 267; i++) begin
				op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6))
						: 3'($urandom_range(5));
				send_op(op, pick_num(), ($urandom_range(60) == 0) ? 31'd0 : pick_den(),
						pick_num(), ($urandom_range(60) == 0) ? 31'd0 : pick_den());
			end
		end
		s_axis_tvalid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (fail_count == 0)
			$display("[rational_arithmetic_unit] OK");
		else
			$display("[rational_arithmetic_unit] ERROR");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/rau_pkg.sv
rtl/rau_ctrl.sv
rtl/rau_datapath.sv
rtl/rational_arithmetic_unit.sv
tb/rational_arithmetic_unit_checker.sv
tb/rational_arithmetic_unit_test.sv
